### rtl/core/ghp_pkg.sv
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants of the generational handle pool: field widths,
// operation and phase codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ghp_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int ID_W    = 32;
  localparam int SLOT_W  = 8;
  localparam int GEN_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Stream payload widths (whole bytes)
  localparam int IN_TDATA_W  = 136;  // key, source, parent, slot, generation
  localparam int OUT_TDATA_W = 48;   // ok, slot, generation, zero fill

  localparam int DEFAULT_POOL_SLOTS = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LAST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_PARENT = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_BIND    = 2'd0,
    OP_BIRTH   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_FREE  = 2'd0,
    PH_BOUND = 2'd1,
    PH_BORN  = 2'd2
  } phase_t;

  // One slot of the pool as held in the slot memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [GEN_W-1:0] gen;
    phase_t           phase;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_EVAL,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic capture;      // load the input item
    logic scan_start;   // clear scan counter and scan results
    logic scan_read;    // read slot at scan counter, advance counter
    logic slot_read;    // read slot named by the item
    logic bind_commit;  // decide bind, write slot, load pending result
    logic slot_commit;  // decide birth or release, write slot, load result
    logic refuse;       // load a refusal as pending result
    logic out_load;     // move pending result into the output register
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bind_pass;
    logic            scan_last;
    logic            out_free;
  } status_t;

endpackage

### rtl/core/ghp_ctrl.sv
// ----------------------------------------------------------------------------
// ghp_ctrl
// Controller of the handle pool: sequences item capture, the slot scan of a
// bind, the single slot lookup of birth and release, and the result hand-off.
// ----------------------------------------------------------------------------
module ghp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ghp_pkg::status_t  sts,
  output ghp_pkg::cmd_t     cmd
);

  ghp_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ghp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ghp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ghp_pkg::ST_DECODE;
        end
      end
      ghp_pkg::ST_DECODE: begin
        unique case (sts.op)
          ghp_pkg::OP_BIND: begin
            cmd.scan_start = 1'b1;
            state_next     = sts.bind_pass ? ghp_pkg::ST_SCAN : ghp_pkg::ST_COMMIT;
          end
          ghp_pkg::OP_BIRTH, ghp_pkg::OP_RELEASE: begin
            cmd.slot_read = 1'b1;
            state_next    = ghp_pkg::ST_EVAL;
          end
          default: begin
            cmd.refuse = 1'b1;
            state_next = ghp_pkg::ST_RESPOND;
          end
        endcase
      end
      ghp_pkg::ST_SCAN: begin
        cmd.scan_read = 1'b1;
        if (sts.scan_last) begin
          state_next = ghp_pkg::ST_DRAIN;
        end
      end
      ghp_pkg::ST_DRAIN: begin
        // last read data is folded into the scan result here
        state_next = ghp_pkg::ST_COMMIT;
      end
      ghp_pkg::ST_COMMIT: begin
        cmd.bind_commit = 1'b1;
        state_next      = ghp_pkg::ST_RESPOND;
      end
      ghp_pkg::ST_EVAL: begin
        cmd.slot_commit = 1'b1;
        state_next      = ghp_pkg::ST_RESPOND;
      end
      ghp_pkg::ST_RESPOND: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ghp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ghp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/ghp_datapath.sv
// ----------------------------------------------------------------------------
// ghp_datapath
// Datapath of the handle pool: configuration registers, item registers, the
// slot memory with per-slot written bits, the scan counter and accumulators,
// the commit logic and the output register.
// ----------------------------------------------------------------------------
module ghp_datapath #(
  parameter int POOL_SLOTS = ghp_pkg::DEFAULT_POOL_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [ghp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ghp_pkg::CFG_W-1:0]        cfg_data,
  // input payload
  input  logic [ghp_pkg::IN_TDATA_W-1:0]   in_data,
  input  logic [ghp_pkg::OP_W-1:0]         in_user,
  // output stream
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ghp_pkg::OUT_TDATA_W-1:0]  out_data,
  // controller link
  input  ghp_pkg::cmd_t                    cmd,
  output ghp_pkg::status_t                 sts
);

  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);
  localparam int PAD_W = ghp_pkg::OUT_TDATA_W - 1 - ghp_pkg::SLOT_W - ghp_pkg::GEN_W;

  // Configuration registers
  logic [ghp_pkg::ID_W-1:0] source_first, source_last, required_parent;

  // Item registers
  logic [ghp_pkg::OP_W-1:0]   item_op;
  logic [ghp_pkg::KEY_W-1:0]  item_key;
  logic [ghp_pkg::ID_W-1:0]   item_src;
  logic [ghp_pkg::ID_W-1:0]   item_parent;
  logic [ghp_pkg::SLOT_W-1:0] item_slot;
  logic [ghp_pkg::GEN_W-1:0]  item_gen;

  // Slot memory and written bits
  ghp_pkg::entry_t   mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] touched;

  // Read side
  ghp_pkg::entry_t   rd_entry;
  logic              rd_touched;
  logic              rd_scan;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  rd_addr;

  // Scan counter and accumulators
  logic [IDX_W-1:0]         scan_cnt;
  logic                     dup_found;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [ghp_pkg::GEN_W-1:0] free_gen;

  // Pending result and output register
  logic                      res_ok;
  logic [ghp_pkg::SLOT_W-1:0] res_slot;
  logic [ghp_pkg::GEN_W-1:0]  res_gen;
  logic                      out_ok;
  logic [ghp_pkg::SLOT_W-1:0] out_slot;
  logic [ghp_pkg::GEN_W-1:0]  out_gen;

  // Decode logic
  logic                      bind_pass;
  logic                      slot_in_range;
  ghp_pkg::phase_t           eff_phase;
  logic [ghp_pkg::GEN_W-1:0] eff_gen;
  logic [ghp_pkg::GEN_W-1:0] gen_inc;
  logic [ghp_pkg::GEN_W-1:0] bind_gen;
  logic                      bind_ok;
  logic                      live;
  logic                      slot_ok;
  logic                      mem_we;
  logic [IDX_W-1:0]          wr_addr;
  ghp_pkg::entry_t           wr_entry;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      source_first    <= '0;
      source_last     <= '1;
      required_parent <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ghp_pkg::CFG_SOURCE_FIRST:    source_first    <= cfg_data;
        ghp_pkg::CFG_SOURCE_LAST:     source_last     <= cfg_data;
        ghp_pkg::CFG_REQUIRED_PARENT: required_parent <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op     <= in_user;
      item_key    <= in_data[31:0];
      item_src    <= in_data[63:32];
      item_parent <= in_data[95:64];
      item_slot   <= in_data[103:96];
      item_gen    <= in_data[135:104];
    end
  end

  assign bind_pass = (item_src >= source_first) && (item_src <= source_last) &&
                     (item_parent == required_parent);
  assign slot_in_range = {1'b0, item_slot} < 9'(POOL_SLOTS);

  // Read address: scan counter or the item's slot
  always_comb begin
    if (cmd.scan_read) begin
      rd_addr = scan_cnt;
    end else if (cmd.slot_read && slot_in_range) begin
      rd_addr = item_slot[IDX_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry   <= mem[rd_addr];
    rd_touched <= touched[rd_addr];
    rd_idx     <= rd_addr;
  end

  // Written bits: a slot never written reads as free with generation zero
  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
      rd_scan <= 1'b0;
    end else begin
      if (mem_we) begin
        touched[wr_addr] <= 1'b1;
      end
      rd_scan <= cmd.scan_read;
    end
  end

  assign eff_phase = rd_touched ? rd_entry.phase : ghp_pkg::PH_FREE;
  assign eff_gen   = rd_touched ? rd_entry.gen   : '0;

  // Scan counter and accumulators
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_cnt   <= '0;
      dup_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (cmd.scan_read) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (rd_scan) begin
        if (eff_phase != ghp_pkg::PH_FREE && rd_entry.key == item_key) begin
          dup_found <= 1'b1;
        end
        if (eff_phase == ghp_pkg::PH_FREE && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
          free_gen   <= eff_gen;
        end
      end
    end
  end

  // Commit decisions
  assign bind_gen = (free_gen == '0) ? ghp_pkg::GEN_W'(1) : free_gen;
  assign bind_ok  = bind_pass && !dup_found && free_found;
  assign gen_inc  = (eff_gen + 1'b1 == '0) ? ghp_pkg::GEN_W'(1) : eff_gen + 1'b1;
  assign live     = (item_gen != '0) && slot_in_range && (eff_gen == item_gen) &&
                    (eff_phase != ghp_pkg::PH_FREE);
  assign slot_ok  = live && ((item_op == ghp_pkg::OP_RELEASE) ||
                             (eff_phase == ghp_pkg::PH_BOUND));

  always_comb begin
    mem_we   = 1'b0;
    wr_addr  = rd_idx;
    wr_entry = rd_entry;
    if (cmd.bind_commit) begin
      mem_we         = bind_ok;
      wr_addr        = free_idx;
      wr_entry.key   = item_key;
      wr_entry.gen   = bind_gen;
      wr_entry.phase = ghp_pkg::PH_BOUND;
    end else if (cmd.slot_commit) begin
      mem_we = slot_ok;
      if (item_op == ghp_pkg::OP_RELEASE) begin
        wr_entry.key   = '0;
        wr_entry.gen   = gen_inc;
        wr_entry.phase = ghp_pkg::PH_FREE;
      end else begin
        wr_entry.phase = ghp_pkg::PH_BORN;
      end
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.bind_commit) begin
      res_ok   <= bind_ok;
      res_slot <= bind_ok ? ghp_pkg::SLOT_W'(free_idx) : '0;
      res_gen  <= bind_ok ? bind_gen : '0;
    end else if (cmd.slot_commit) begin
      res_ok   <= slot_ok;
      res_slot <= '0;
      res_gen  <= '0;
    end else if (cmd.refuse) begin
      res_ok   <= 1'b0;
      res_slot <= '0;
      res_gen  <= '0;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok   <= res_ok;
      out_slot <= res_slot;
      out_gen  <= res_gen;
    end
  end

  assign out_data = {PAD_W'(0), out_gen, out_slot, out_ok};

  assign sts.op        = item_op;
  assign sts.bind_pass = bind_pass;
  assign sts.scan_last = (scan_cnt == LAST_IDX);
  assign sts.out_free  = !out_valid || out_ready;

`ifndef ASSERT_OFF
  // A scan data beat always follows a scan read in the cycle before
  a_scan_beat: assert property (@(posedge clk) disable iff (rst)
    rd_scan |-> $past(cmd.scan_read))
    else $error("scan data without a scan read");

  // A granted bind never hands out generation zero
  a_bind_gen: assert property (@(posedge clk) disable iff (rst)
    cmd.bind_commit && bind_ok |=> res_ok && res_gen != '0)
    else $error("bind granted with generation zero");

  // The result is never loaded over one still waiting for transfer
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // A granted release leaves its slot marked written
  a_release_free: assert property (@(posedge clk) disable iff (rst)
    cmd.slot_commit && slot_ok && item_op == ghp_pkg::OP_RELEASE |=>
      touched[$past(wr_addr)])
    else $error("released slot not marked written");
`endif

endmodule

### rtl/core/generational_handle_pool.sv
// ----------------------------------------------------------------------------
// generational_handle_pool
// Fixed pool of slots handing out generational handles (slot, generation)
// for bind, birth and release requests.
// ----------------------------------------------------------------------------
// Bind: the scan reads one slot per cycle over the whole pool (SCAN, then DRAIN),
//   then COMMIT and RESPOND; the next item is taken only after RESPOND hands the result on.
// Birth, release: DECODE, EVAL, RESPOND. Bind refused by its source or parent
//   check: DECODE, COMMIT, RESPOND. Unknown operation: DECODE, RESPOND.
// Reset (rst, synchronous) clears the per-slot written bits, so every slot
//   reads free with generation zero at once; no clearing pass is run.
module generational_handle_pool #(
  parameter int POOL_SLOTS = ghp_pkg::DEFAULT_POOL_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [ghp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ghp_pkg::CFG_W-1:0]        cfg_data,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // owner_key, source, parent, slot_index, handle_generation
  input  logic [ghp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic [ghp_pkg::OP_W-1:0]         s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // ok, out_slot, out_generation, zero fill
  output logic [ghp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  ghp_pkg::cmd_t    cmd;
  ghp_pkg::status_t sts;

  ghp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ghp_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### tb/generational_handle_pool_tb.sv
// ----------------------------------------------------------------------------
// generational_handle_pool_tb
// Self-checking bench for the generational handle pool. A short table of
// directed requests is followed by random phases under several register
// settings. Each accepted request runs through a local model of the pool and
// its reply is queued; each reply transfer is checked field by field against
// the oldest queued reply. Both stream sides idle at random, and once the
// reply side holds off long enough to back the pool up into its input.
// ----------------------------------------------------------------------------
module generational_handle_pool_tb;

  localparam int POOL_N = ghp_pkg::DEFAULT_POOL_SLOTS;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int DIR_N = 21;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 2 * POOL_N + 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [ghp_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ghp_pkg::OP_W-1:0]   op;
    logic [ghp_pkg::KEY_W-1:0]  key;
    logic [ghp_pkg::ID_W-1:0]   src;
    logic [ghp_pkg::ID_W-1:0]   parent;
    logic [ghp_pkg::SLOT_W-1:0] slot;
    logic [ghp_pkg::GEN_W-1:0]  gen;
  } request_t;

  typedef struct packed {
    logic                       ok;
    logic [ghp_pkg::SLOT_W-1:0] slot;
    logic [ghp_pkg::GEN_W-1:0]  gen;
  } reply_t;

  // Directed row: request plus a reply typed in where it is obvious
  typedef struct packed {
    logic [ghp_pkg::OP_W-1:0]   op;
    logic [ghp_pkg::KEY_W-1:0]  key;
    logic [ghp_pkg::ID_W-1:0]   src;
    logic [ghp_pkg::ID_W-1:0]   parent;
    logic [ghp_pkg::SLOT_W-1:0] slot;
    logic [ghp_pkg::GEN_W-1:0]  gen;
    logic                       typed;
    logic                       ok;
    logic [ghp_pkg::SLOT_W-1:0] oslot;
    logic [ghp_pkg::GEN_W-1:0]  ogen;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [ghp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ghp_pkg::CFG_W-1:0] cfg_data = '0;
  logic s_valid = 1'b0;
  logic s_axis_tready;
  logic [ghp_pkg::IN_TDATA_W-1:0] s_data = '0;
  logic [ghp_pkg::OP_W-1:0] s_user = '0;
  logic m_axis_tvalid;
  logic m_ready = 1'b0;
  logic [ghp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  generational_handle_pool #(
    .POOL_SLOTS(POOL_N)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_data),
    .s_axis_tuser(s_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pool model state and register copies
  ghp_pkg::phase_t ph_tbl [POOL_N];
  logic [ghp_pkg::GEN_W-1:0] gen_tbl [POOL_N];
  logic [ghp_pkg::KEY_W-1:0] key_tbl [POOL_N];
  logic [ghp_pkg::ID_W-1:0] src_lo = '0;
  logic [ghp_pkg::ID_W-1:0] src_hi = '1;
  logic [ghp_pkg::ID_W-1:0] want_parent = '0;

  reply_t reply_q [$];
  int mismatch_cnt = 0;
  int reply_idx = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit long_hold_req = 1'b0;

  dir_row_t directed_rows [DIR_N] = '{
    '{ghp_pkg::OP_BIND, 32'h0, 32'h0, 32'h0, 8'h00, 32'h0, 1'b1, 1'b1, 8'd0, 32'd1},
    '{ghp_pkg::OP_BIND, '1, '1, 32'h0, 8'hFF, '1, 1'b1, 1'b1, 8'd1, 32'd1},
    '{ghp_pkg::OP_BIND, 32'h0, 32'h5, 32'h0, 8'h00, 32'h0, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIND, 32'h7, 32'h0, '1, 8'h00, 32'h0, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIRTH, 32'h0, 32'h0, 32'h0, 8'd0, 32'd1, 1'b1, 1'b1, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIRTH, 32'h0, 32'h0, 32'h0, 8'd0, 32'd1, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIRTH, '1, '1, '1, 8'hFF, 32'd1, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIRTH, 32'h0, 32'h0, 32'h0, 8'd16, 32'd1, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_RELEASE, 32'h0, 32'h0, 32'h0, 8'd1, 32'd0, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_RELEASE, 32'h0, 32'h0, 32'h0, 8'd1, '1, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_RELEASE, 32'h0, 32'h0, 32'h0, 8'd0, 32'd1, 1'b1, 1'b1, 8'd0, 32'd0},
    '{ghp_pkg::OP_RELEASE, 32'h0, 32'h0, 32'h0, 8'd1, 32'd1, 1'b1, 1'b1, 8'd0, 32'd0},
    '{OP_UNKNOWN, '1, '1, '1, 8'hFF, '1, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIRTH, 32'h0, 32'h0, 32'h0, 8'd0, 32'd2, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIND, 32'h0, 32'h0, 32'h0, 8'h00, 32'h0, 1'b0, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIND, '1, 32'h7FFF_FFFF, 32'h0, 8'h00, 32'h0, 1'b0, 1'b0, 8'd0,
      32'd0},
    '{ghp_pkg::OP_RELEASE, 32'h0, 32'h0, 32'h0, 8'd0, 32'd1, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIRTH, 32'h0, 32'h0, 32'h0, 8'd1, 32'd2, 1'b0, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_RELEASE, 32'h0, 32'h0, 32'h0, 8'd15, 32'd0, 1'b1, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIND, 32'hA5A5_A5A5, 32'h8000_0000, 32'h0, 8'h5A, 32'h5A5A_5A5A,
      1'b0, 1'b0, 8'd0, 32'd0},
    '{ghp_pkg::OP_BIRTH, 32'h0, 32'h0, 32'h0, 8'h7F, 32'h5A5A_5A5A, 1'b1, 1'b0, 8'd0,
      32'd0}
  };

  function automatic bit handle_live(input logic [ghp_pkg::SLOT_W-1:0] s,
                                     input logic [ghp_pkg::GEN_W-1:0] g);
    if (g == '0 || s >= POOL_N) return 1'b0;
    return gen_tbl[s] == g && ph_tbl[s] != ghp_pkg::PH_FREE;
  endfunction

  // Apply one request to the pool model and return its reply
  function automatic reply_t pool_apply(input request_t r);
    reply_t res;
    int free_at;
    bit dup;
    int i;
    res = '0;
    free_at = -1;
    dup = 1'b0;
    case (r.op)
      ghp_pkg::OP_BIND: begin
        if (r.src >= src_lo && r.src <= src_hi && r.parent == want_parent) begin
          for (i = 0; i < POOL_N; i++) begin
            if (ph_tbl[i] != ghp_pkg::PH_FREE && key_tbl[i] == r.key) dup = 1'b1;
            if (ph_tbl[i] == ghp_pkg::PH_FREE && free_at < 0) free_at = i;
          end
          if (!dup && free_at >= 0) begin
            if (gen_tbl[free_at] == '0) gen_tbl[free_at] = 32'd1;
            ph_tbl[free_at] = ghp_pkg::PH_BOUND;
            key_tbl[free_at] = r.key;
            res.ok = 1'b1;
            res.slot = ghp_pkg::SLOT_W'(free_at);
            res.gen = gen_tbl[free_at];
          end
        end
      end
      ghp_pkg::OP_BIRTH: begin
        if (handle_live(r.slot, r.gen) && ph_tbl[r.slot] == ghp_pkg::PH_BOUND) begin
          ph_tbl[r.slot] = ghp_pkg::PH_BORN;
          res.ok = 1'b1;
        end
      end
      ghp_pkg::OP_RELEASE: begin
        if (handle_live(r.slot, r.gen)) begin
          ph_tbl[r.slot] = ghp_pkg::PH_FREE;
          key_tbl[r.slot] = '0;
          gen_tbl[r.slot] = gen_tbl[r.slot] + 32'd1;
          if (gen_tbl[r.slot] == '0) gen_tbl[r.slot] = 32'd1;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic bit pick_live(output int s);
    int live [$];
    int i;
    for (i = 0; i < POOL_N; i++) begin
      if (ph_tbl[i] != ghp_pkg::PH_FREE) live.push_back(i);
    end
    s = 0;
    if (live.size() == 0) return 1'b0;
    s = live[$urandom_range(0, live.size() - 1)];
    return 1'b1;
  endfunction

  // Source id inside the configured range, edges favored
  function automatic logic [ghp_pkg::ID_W-1:0] pick_source();
    logic [ghp_pkg::ID_W:0] span;
    if (src_lo > src_hi) return $urandom;
    case ($urandom_range(0, 3))
      0: return src_lo;
      1: return src_hi;
      default: begin
        span = {1'b0, src_hi} - {1'b0, src_lo} + 33'd1;
        return src_lo + ghp_pkg::ID_W'({$urandom, $urandom} % span);
      end
    endcase
  endfunction

  // Random request: mostly well-formed binds and live handles, some noise
  function automatic request_t make_request(input int bind_pct);
    request_t r;
    int roll;
    int s;
    r.op = ghp_pkg::OP_BIND;
    r.key = $urandom;
    r.src = $urandom;
    r.parent = $urandom;
    r.slot = ghp_pkg::SLOT_W'($urandom);
    r.gen = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      r.op = OP_UNKNOWN;
    end else if (roll < 3 + bind_pct) begin
      if ($urandom_range(0, 9) != 0) r.src = pick_source();
      if ($urandom_range(0, 9) != 0) r.parent = want_parent;
      case ($urandom_range(0, 5))
        0: if (pick_live(s)) r.key = key_tbl[s];
        1: r.key = $urandom_range(0, 15);
        default: ;
      endcase
    end else begin
      r.op = $urandom_range(0, 1) ? ghp_pkg::OP_BIRTH : ghp_pkg::OP_RELEASE;
      roll = $urandom_range(0, 99);
      if (roll < 75 && pick_live(s)) begin
        r.slot = ghp_pkg::SLOT_W'(s);
        r.gen = gen_tbl[s];
      end else if (roll < 82) begin
        // stale or future generation
        r.slot = ghp_pkg::SLOT_W'($urandom_range(0, POOL_N - 1));
        r.gen = gen_tbl[r.slot] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
      end else if (roll < 88) begin
        // matching generation on a slot that may be free
        r.slot = ghp_pkg::SLOT_W'($urandom_range(0, POOL_N - 1));
        r.gen = gen_tbl[r.slot];
      end else if (roll < 93) begin
        r.slot = ghp_pkg::SLOT_W'($urandom_range(0, POOL_N - 1));
        r.gen = '0;
      end
    end
    return r;
  endfunction

  task automatic cfg_set(input logic [ghp_pkg::CFG_W-1:0] first,
                         input logic [ghp_pkg::CFG_W-1:0] last,
                         input logic [ghp_pkg::CFG_W-1:0] parent);
    cfg_wr_en <= 1'b1;
    cfg_index <= ghp_pkg::CFG_SOURCE_FIRST;
    cfg_data <= first;
    @(posedge clk);
    cfg_index <= ghp_pkg::CFG_SOURCE_LAST;
    cfg_data <= last;
    @(posedge clk);
    cfg_index <= ghp_pkg::CFG_REQUIRED_PARENT;
    cfg_data <= parent;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    src_lo = first;
    src_hi = last;
    want_parent = parent;
  endtask

  // Offer one request; queue its reply once the transfer happens
  task automatic send_request(input request_t r, input reply_t want);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {r.gen, r.slot, r.parent, r.src, r.key};
    s_user <= r.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    reply_q.push_back(want);
  endtask

  task automatic wait_replies(input int settle);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    request_t r;
    reply_t want;
    logic [ghp_pkg::ID_W-1:0] a, b;
    int bind_pct;
    int i, p, n;
    for (i = 0; i < POOL_N; i++) begin
      ph_tbl[i] = ghp_pkg::PH_FREE;
      gen_tbl[i] = '0;
      key_tbl[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under reset register values
    tx_idle_pct = 20;
    rx_idle_pct = 6;
    for (i = 0; i < DIR_N; i++) begin
      r = '{directed_rows[i].op, directed_rows[i].key, directed_rows[i].src,
            directed_rows[i].parent, directed_rows[i].slot, directed_rows[i].gen};
      want = pool_apply(r);
      if (directed_rows[i].typed) begin
        want = '{directed_rows[i].ok, directed_rows[i].oslot, directed_rows[i].ogen};
      end
      send_request(r, want);
    end
    s_valid <= 1'b0;
    wait_replies(4);

    // random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin bind_pct = 70; tx_idle_pct = 20; rx_idle_pct = 6; end
        1: begin
          cfg_set(32'h0000_1000, 32'h0000_1FFF, 32'h1234_5678);
          bind_pct = 45; tx_idle_pct = 0; rx_idle_pct = 8;
        end
        2: begin
          cfg_set('1, '1, '1);
          bind_pct = 70; tx_idle_pct = 15; rx_idle_pct = 5;
        end
        3: begin
          cfg_set('0, '0, '0);
          bind_pct = 15; tx_idle_pct = 25; rx_idle_pct = 0;
        end
        4: begin
          // empty source range refuses every bind
          cfg_set(32'h8000_0001, 32'h8000_0000, $urandom);
          bind_pct = 50; tx_idle_pct = 20; rx_idle_pct = 6;
        end
        5: begin
          a = $urandom;
          b = $urandom;
          if (a > b) cfg_set(b, a, $urandom);
          else cfg_set(a, b, $urandom);
          bind_pct = 60; tx_idle_pct = 10; rx_idle_pct = 8;
        end
        6: begin
          cfg_set('0, '1, $urandom);
          bind_pct = 40; tx_idle_pct = 0; rx_idle_pct = 4;
        end
        default: begin
          // closing stretch without idling
          cfg_set('0, '1, '0);
          bind_pct = 45; tx_idle_pct = 0; rx_idle_pct = 0;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) long_hold_req = 1'b1;
        r = make_request(bind_pct);
        want = pool_apply(r);
        send_request(r, want);
      end
      s_valid <= 1'b0;
      wait_replies(4);
    end

    wait_replies(DRAIN_CYCLES);
    if (mismatch_cnt == 0 && reply_q.size() == 0) begin
      $display("generational_handle_pool_tb passed");
    end else begin
      $display("generational_handle_pool_tb failed");
    end
    $finish;
  end

  // Reply side: random stall bursts, one long hold-off on request
  initial begin : reply_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && rx_idle_pct != 0 &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        hold_left = $urandom_range(1, 11);
      end
      if (hold_left != 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Check each reply transfer against the oldest queued reply
  always @(posedge clk) begin : reply_check
    reply_t want;
    reply_t got;
    if (!rst && m_axis_tvalid && m_ready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[40:9]};
      if (reply_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("reply %0d: none pending, got ok=%0d slot=%0d gen=%h",
                   reply_idx, got.ok, got.slot, got.gen);
        end
      end else begin
        want = reply_q.pop_front();
        if (got.ok !== want.ok || got.slot !== want.slot || got.gen !== want.gen ||
            m_axis_tdata[ghp_pkg::OUT_TDATA_W-1:41] !== '0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("reply %0d: expected ok=%0d slot=%0d gen=%h",
                     reply_idx, want.ok, want.slot, want.gen);
            $display("reply %0d: got ok=%0d slot=%0d gen=%h fill=%h",
                     reply_idx, got.ok, got.slot, got.gen,
                     m_axis_tdata[ghp_pkg::OUT_TDATA_W-1:41]);
          end
        end
      end
      reply_idx++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("generational_handle_pool_tb failed");
      $finish;
    end
  end

endmodule
